// ===== design/bfnq_pkg.sv =====
// Shared types and constants for the best-fit normal quantizer.
// Holds the controller/datapath command and status structs and the loop step counts.
// No dependencies.
package bfnq_pkg;

  localparam int MAX_RADIUS_DEF = 3;
  localparam int RADIUS_W       = 2;
  localparam int ACC_STEPS      = 3;   // one component per cycle
  localparam int SQRT_STEPS     = 17;  // one root bit per cycle
  localparam int DIV_STEPS      = 31;  // one quotient bit per cycle
  localparam int CNT_W          = 5;

  // integer form of |sqrt(S)/255 - 1| <= 0.03
  localparam logic [17:0] LEN_SQ_MIN = 18'd61183;
  localparam logic [17:0] LEN_SQ_MAX = 18'd68985;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       direct;
    logic       init_iter;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       update;
    logic       advance;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic len_ok;
    logic last;
  } status_t;

endpackage

// ===== design/best_fit_normal_quantizer.sv =====
// Top level of the best-fit normal quantizer: sequencer plus datapath.
// Depends on bfnq_pkg, bfnq_ctrl and bfnq_dpath.
// Holds the interface checks at the end.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | in_normal_x/y/z                         | beat taken on start && !busy
//  result  | out_code_r/g/b                          | one-cycle out_valid strobe
//  config  | cfg_wdata (search_radius)               | written on cfg_we
//
// Each accepted item walks the whole candidate cube: every candidate takes the length test,
// and each passing code also runs the shared bit-serial square root and divider.
// Reset: synchronous, active low; clears the sequencer and sets the radius to 3.
// Stalls: none on the result side; busy stays high from acceptance until the strobe.
module best_fit_normal_quantizer #(
  parameter int MAX_RADIUS = bfnq_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            in_normal_x,
  input  logic signed [15:0]            in_normal_y,
  input  logic signed [15:0]            in_normal_z,
  output logic                          out_valid,
  output logic [7:0]                    out_code_r,
  output logic [7:0]                    out_code_g,
  output logic [7:0]                    out_code_b,
  input  logic                          cfg_we,
  input  logic [bfnq_pkg::RADIUS_W-1:0] cfg_wdata
);

  bfnq_pkg::cmd_t    cmd;
  bfnq_pkg::status_t status;

  // sequencer: walks the cube, paces root and divide units
  bfnq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: arithmetic, counters, best-code tracking, result register
  bfnq_dpath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_normal_x (in_normal_x),
    .in_normal_y (in_normal_y),
    .in_normal_z (in_normal_z),
    .cmd         (cmd),
    .status      (status),
    .out_code_r  (out_code_r),
    .out_code_g  (out_code_g),
    .out_code_b  (out_code_b)
  );

`ifndef ASSERT_OFF
  // the strobe comes only once the item is finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  // busy drops only with the result strobe
  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy dropped without a result");

  // no back-to-back strobes: each item produces one result
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("repeated result strobe");
`endif

endmodule

// ===== design/bfnq_ctrl.sv =====
// Sequencer for the best-fit normal quantizer.
// Walks the candidate cube and paces the iterative root and divide units.
// Depends on bfnq_pkg.
module bfnq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output logic             out_valid,
  input  bfnq_pkg::status_t status,
  output bfnq_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIRECT, S_INIT, S_ACC, S_CHK, S_SQRT,
    S_DINIT, S_DIV, S_UPD, S_NEXT, S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [bfnq_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         busy_r, out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.acc_sel = cnt_r[1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DIRECT;
        end
      end
      S_DIRECT: begin
        cmd.direct = 1'b1;
        state_nxt  = S_INIT;
      end
      S_INIT: begin
        cmd.init_iter = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        if (cnt_r == bfnq_pkg::CNT_W'(bfnq_pkg::ACC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_CHK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CHK: begin
        if (status.len_ok) begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = S_SQRT;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == bfnq_pkg::CNT_W'(bfnq_pkg::SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DINIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == bfnq_pkg::CNT_W'(bfnq_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        if (status.last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_ACC;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (state_r == S_IDLE && start) begin
        busy_r <= 1'b1;
      end else if (state_r == S_DONE) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// ===== design/bfnq_dpath.sv =====
// Datapath of the best-fit normal quantizer: direct codes, candidate counters,
// length and dot accumulators, bit-serial square root and divider, best tracking.
// Depends on bfnq_pkg.
module bfnq_dpath #(
  parameter int MAX_RADIUS = bfnq_pkg::MAX_RADIUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bfnq_pkg::RADIUS_W-1:0]     cfg_wdata,
  input  logic signed [15:0]                in_normal_x,
  input  logic signed [15:0]                in_normal_y,
  input  logic signed [15:0]                in_normal_z,
  input  bfnq_pkg::cmd_t                    cmd,
  output bfnq_pkg::status_t                 status,
  output logic [7:0]                        out_code_r,
  output logic [7:0]                        out_code_g,
  output logic [7:0]                        out_code_b
);

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  logic [bfnq_pkg::RADIUS_W-1:0] radius_r;
  logic signed [15:0] nx_r, ny_r, nz_r;
  logic [7:0]  bx_r, by_r, bz_r;
  logic [7:0]  lox_r, loy_r, loz_r, hix_r, hiy_r, hiz_r;
  logic [7:0]  x_r, y_r, z_r;
  logic [17:0] s_acc_r;
  logic signed [26:0] p_acc_r;
  logic [33:0] rad_r;
  logic [19:0] srem_r;
  logic [16:0] root_r;
  logic [25:0] pmag_r;
  logic        psign_r;
  logic [17:0] drem_r;
  logic [30:0] dq_r;
  logic        found_r;
  logic [31:0] best_r;
  logic [7:0]  cr_r, cg_r, cb_r;
  logic [7:0]  oc_r_r, oc_g_r, oc_b_r;

  // direct quantization
  logic [16:0] az;
  logic [24:0] qx, qy;
  logic [23:0] qz;
  assign az = nz_r[15] ? 17'(-$signed({nz_r[15], nz_r})) : 17'({1'b0, nz_r});

  logic [15:0] dux, duy;
  assign dux = nx_r ^ 16'h8000;
  assign duy = ny_r ^ 16'h8000;
  assign qx  = {1'b0, dux, 8'b0} - {9'b0, dux} + 25'd32768;
  assign qy  = {1'b0, duy, 8'b0} - {9'b0, duy} + 25'd32768;
  assign qz  = 24'({az, 8'b0} - {8'b0, az} + 25'd16384);

  // search bounds
  logic [2:0] d;
  assign d = (32'(radius_r) > MAX_RADIUS) ? 3'(MAX_RADIUS) : {1'b0, radius_r};

  function automatic logic [7:0] lo_of(input logic [7:0] b, input logic [2:0] r);
    logic [7:0] res;
    res = (b < {5'b0, r}) ? 8'd0 : b - {5'b0, r};
    return res;
  endfunction

  function automatic logic [7:0] hi_of(input logic [7:0] b, input logic [2:0] r);
    logic [8:0] sum;
    sum = {1'b0, b} + {6'b0, r};
    return sum[8] ? 8'd255 : sum[7:0];
  endfunction

  // candidate component products
  logic [7:0]         sel_code;
  logic signed [15:0] sel_n;
  logic signed [9:0]  comp;
  logic signed [19:0] sq;
  logic signed [25:0] prod;

  always_comb begin
    unique case (cmd.acc_sel)
      bfnq_pkg::COMP_X: begin sel_code = x_r; sel_n = nx_r; end
      bfnq_pkg::COMP_Y: begin sel_code = y_r; sel_n = ny_r; end
      default:          begin sel_code = z_r; sel_n = nz_r; end
    endcase
    if (cmd.acc_sel == bfnq_pkg::COMP_Z) begin
      comp = -$signed({2'b00, sel_code});
    end else begin
      comp = $signed({1'b0, sel_code, 1'b0}) - 10'sd255;
    end
  end

  assign sq   = comp * comp;
  assign prod = sel_n * comp;

  // root step: two radicand bits in, one root bit out
  logic [19:0] s_try, s_trial;
  assign s_try   = {srem_r[17:0], rad_r[33:32]};
  assign s_trial = {1'b0, root_r, 2'b01};

  // divide step: one quotient bit out
  logic [18:0] d_try;
  assign d_try = {drem_r, dq_r[30]};

  logic [31:0] cost, qv;
  always_comb begin
    qv = {1'b0, dq_r};
    if (psign_r) begin
      cost = ONE_Q30 + qv;
    end else if (qv >= ONE_Q30) begin
      cost = qv - ONE_Q30;
    end else begin
      cost = ONE_Q30 - qv;
    end
  end

  assign status.len_ok = (s_acc_r >= bfnq_pkg::LEN_SQ_MIN) && (s_acc_r <= bfnq_pkg::LEN_SQ_MAX);
  assign status.last   = (x_r == hix_r) && (y_r == hiy_r) && (z_r == hiz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= bfnq_pkg::RADIUS_W'(3);
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      nx_r <= in_normal_x;
      ny_r <= in_normal_y;
      nz_r <= in_normal_z;
    end
    if (cmd.direct) begin
      bx_r <= qx[23:16];
      by_r <= qy[23:16];
      bz_r <= qz[22:15];
    end
    if (cmd.init_iter) begin
      lox_r   <= lo_of(bx_r, d);
      loy_r   <= lo_of(by_r, d);
      loz_r   <= lo_of(bz_r, d);
      hix_r   <= hi_of(bx_r, d);
      hiy_r   <= hi_of(by_r, d);
      hiz_r   <= hi_of(bz_r, d);
      x_r     <= lo_of(bx_r, d);
      y_r     <= lo_of(by_r, d);
      z_r     <= lo_of(bz_r, d);
      found_r <= 1'b0;
      cr_r    <= bx_r;
      cg_r    <= by_r;
      cb_r    <= bz_r;
    end
    if (cmd.acc_en) begin
      if (cmd.acc_sel == bfnq_pkg::COMP_X) begin
        s_acc_r <= 18'(sq);
        p_acc_r <= 27'(prod);
      end else begin
        s_acc_r <= s_acc_r + 18'(sq);
        p_acc_r <= p_acc_r + 27'(prod);
      end
    end
    if (cmd.sqrt_init) begin
      rad_r   <= {s_acc_r, 16'b0};
      srem_r  <= '0;
      root_r  <= '0;
      psign_r <= p_acc_r[26];
      pmag_r  <= p_acc_r[26] ? 26'(-p_acc_r) : 26'(p_acc_r);
    end
    if (cmd.sqrt_step) begin
      rad_r <= {rad_r[31:0], 2'b00};
      if (s_try >= s_trial) begin
        srem_r <= s_try - s_trial;
        root_r <= {root_r[15:0], 1'b1};
      end else begin
        srem_r <= s_try;
        root_r <= {root_r[15:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      drem_r <= pmag_r[25:8];
      dq_r   <= {pmag_r[7:0], 23'b0};
    end
    if (cmd.div_step) begin
      if (d_try >= {2'b00, root_r}) begin
        drem_r <= 18'(d_try - {2'b00, root_r});
        dq_r   <= {dq_r[29:0], 1'b1};
      end else begin
        drem_r <= d_try[17:0];
        dq_r   <= {dq_r[29:0], 1'b0};
      end
    end
    if (cmd.update && (!found_r || cost < best_r)) begin
      found_r <= 1'b1;
      best_r  <= cost;
      cr_r    <= x_r;
      cg_r    <= y_r;
      cb_r    <= z_r;
    end
    if (cmd.advance) begin
      if (z_r != hiz_r) begin
        z_r <= z_r + 1'b1;
      end else begin
        z_r <= loz_r;
        if (y_r != hiy_r) begin
          y_r <= y_r + 1'b1;
        end else begin
          y_r <= loy_r;
          x_r <= x_r + 1'b1;
        end
      end
    end
    if (cmd.finish) begin
      oc_r_r <= cr_r;
      oc_g_r <= cg_r;
      oc_b_r <= cb_r;
    end
  end

  assign out_code_r = oc_r_r;
  assign out_code_g = oc_g_r;
  assign out_code_b = oc_b_r;

endmodule
